// ===== rtl/ecal_pkg.sv =====
// Package for the epoch seconds to calendar converter.
// Holds the result and status types, the sequencer states and calendar constants.
// No dependencies; ecal_core, the top level and the testbench import it.
package ecal_pkg;

    localparam int unsigned SECONDS_PER_DAY  = 86400;
    localparam int unsigned SECONDS_PER_HOUR = 3600;
    localparam int unsigned SECONDS_PER_MIN  = 60;

    // Quotient widths of the three restoring divisions.
    localparam int unsigned DAY_Q_BITS  = 16;
    localparam int unsigned HOUR_Q_BITS = 5;
    localparam int unsigned MIN_Q_BITS  = 6;

    localparam logic [31:0] DAY_DIV_START  = 32'(SECONDS_PER_DAY)  << (DAY_Q_BITS - 1);
    localparam logic [31:0] HOUR_DIV_START = 32'(SECONDS_PER_HOUR) << (HOUR_Q_BITS - 1);
    localparam logic [31:0] MIN_DIV_START  = 32'(SECONDS_PER_MIN)  << (MIN_Q_BITS - 1);

    localparam logic [11:0] BASE_YEAR       = 12'd1970;
    localparam logic [1:0]  BASE_YEAR_MOD4   = 2'd2;
    localparam logic [6:0]  BASE_YEAR_MOD100 = 7'd70;
    localparam logic [8:0]  BASE_YEAR_MOD400 = 9'd370;

    localparam logic [15:0] DAYS_COMMON_YEAR   = 16'd365;
    localparam logic [15:0] DAYS_LEAP_YEAR     = 16'd366;
    localparam logic [15:0] DAYS_LEAP_FEBRUARY = 16'd29;

    localparam logic [3:0] MONTH_FEBRUARY = 4'd1;
    localparam logic [3:0] MONTH_DECEMBER = 4'd11;

    // 1970-01-01 was a Thursday.
    localparam logic [2:0] EPOCH_WEEKDAY = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DAYS,
        ST_YEARS,
        ST_MONTHS,
        ST_HOURS,
        ST_MINUTES,
        ST_DONE
    } t_ecal_state;

    typedef struct packed {
        logic ready;
        logic done;
    } t_ecal_status;

    typedef struct packed {
        logic [11:0] calendar_year;
        logic [3:0]  calendar_month;
        logic [4:0]  day_of_month;
        logic [2:0]  weekday_number;
        logic [4:0]  clock_hour;
        logic [5:0]  clock_minute;
        logic [5:0]  clock_second;
    } t_ecal_result;

    // Month length for a zero-based month index.
    function automatic logic [15:0] month_length(input logic [3:0] mon, input logic leap);
        logic [15:0] len;
        unique case (mon)
            4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 16'd31;
            4'd3, 4'd5, 4'd8, 4'd10:                   len = 16'd30;
            4'd1:    len = leap ? DAYS_LEAP_FEBRUARY : 16'd28;
            default: len = 16'd31;
        endcase
        return len;
    endfunction

    // One step of a residue-mod-7 accumulation, most significant bit first.
    function automatic logic [2:0] mod7_step(input logic [2:0] w, input logic b);
        logic [3:0] s;
        s = {w, b};
        return (s >= 4'd7) ? 3'(s - 4'd7) : s[2:0];
    endfunction

endpackage

// ===== rtl/ecal_if.sv =====
// Channel interfaces of the epoch seconds to calendar converter.
// Depends on nothing; the top level uses one of each.
interface ecal_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface ecal_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] calendar_year;
    logic [3:0]  calendar_month;
    logic [4:0]  day_of_month;
    logic [2:0]  weekday_number;
    logic [4:0]  clock_hour;
    logic [5:0]  clock_minute;
    logic [5:0]  clock_second;

    modport source (output valid, output calendar_year, output calendar_month,
                    output day_of_month, output weekday_number, output clock_hour,
                    output clock_minute, output clock_second, input ready);
    modport sink   (input valid, input calendar_year, input calendar_month,
                    input day_of_month, input weekday_number, input clock_hour,
                    input clock_minute, input clock_second, output ready);
endinterface

// ===== rtl/ecal_csub.sv =====
// Shared compare and subtract unit of the converter.
// Pure logic; no package dependencies.
module ecal_csub (
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_ge,
    output logic [31:0] o_diff
);

    logic [32:0] w_sub;

    // The borrow out of the subtraction doubles as the compare result.
    assign w_sub  = {1'b0, i_a} - {1'b0, i_b};
    assign o_ge   = ~w_sub[32];
    assign o_diff = w_sub[31:0];

endmodule

// ===== rtl/ecal_core.sv =====
// Sequencer and working registers of the converter.
// Depends on ecal_pkg and drives the shared ecal_csub unit.
module ecal_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [31:0]           i_secs,
    input  logic                  i_take,
    output ecal_pkg::t_ecal_status o_status,
    output ecal_pkg::t_ecal_result o_result
);
    import ecal_pkg::*;

    t_ecal_state r_state, n_state;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_div, n_div;
    logic [3:0]  r_k, n_k;
    logic [15:0] r_days, n_days;
    logic [2:0]  r_wd, n_wd;
    logic [11:0] r_year, n_year;
    logic [1:0]  r_y4, n_y4;
    logic [6:0]  r_y100, n_y100;
    logic [8:0]  r_y400, n_y400;
    logic [3:0]  r_mon, n_mon;
    logic [4:0]  r_hour, n_hour;
    logic [5:0]  r_minute, n_minute;

    logic        w_leap;
    logic [31:0] w_a, w_b, w_diff;
    logic        w_ge;

    assign w_leap = ((r_y4 == 2'd0) && (r_y100 != 7'd0)) || (r_y400 == 9'd0);

    ecal_csub u_csub (
        .i_a    (w_a),
        .i_b    (w_b),
        .o_ge   (w_ge),
        .o_diff (w_diff)
    );

    // Operand selection for the shared unit.
    always_comb begin
        unique case (r_state)
            ST_YEARS: begin
                w_a = {16'd0, r_days};
                w_b = {16'd0, w_leap ? DAYS_LEAP_YEAR : DAYS_COMMON_YEAR};
            end
            ST_MONTHS: begin
                w_a = {16'd0, r_days};
                w_b = {16'd0, month_length(r_mon, w_leap)};
            end
            default: begin
                w_a = r_rem;
                w_b = r_div;
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_rem    = r_rem;
        n_div    = r_div;
        n_k      = r_k;
        n_days   = r_days;
        n_wd     = r_wd;
        n_year   = r_year;
        n_y4     = r_y4;
        n_y100   = r_y100;
        n_y400   = r_y400;
        n_mon    = r_mon;
        n_hour   = r_hour;
        n_minute = r_minute;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_DAYS;
                    n_rem   = i_secs;
                    n_div   = DAY_DIV_START;
                    n_k     = 4'(DAY_Q_BITS - 1);
                    n_days  = 16'd0;
                    n_wd    = 3'd0;
                end
            end
            ST_DAYS: begin
                if (w_ge) begin
                    n_rem = w_diff;
                end
                n_days = {r_days[14:0], w_ge};
                n_wd   = mod7_step(r_wd, w_ge);
                n_div  = r_div >> 1;
                if (r_k == 4'd0) begin
                    n_state = ST_YEARS;
                    n_year  = BASE_YEAR;
                    n_y4    = BASE_YEAR_MOD4;
                    n_y100  = BASE_YEAR_MOD100;
                    n_y400  = BASE_YEAR_MOD400;
                end else begin
                    n_k = r_k - 4'd1;
                end
            end
            ST_YEARS: begin
                if (w_ge) begin
                    n_days = w_diff[15:0];
                    n_year = r_year + 12'd1;
                    n_y4   = r_y4 + 2'd1;
                    n_y100 = (r_y100 == 7'd99)  ? 7'd0 : r_y100 + 7'd1;
                    n_y400 = (r_y400 == 9'd399) ? 9'd0 : r_y400 + 9'd1;
                end else begin
                    n_state = ST_MONTHS;
                    n_mon   = 4'd0;
                end
            end
            ST_MONTHS: begin
                if (w_ge && (r_mon < MONTH_DECEMBER)) begin
                    n_days = w_diff[15:0];
                    n_mon  = r_mon + 4'd1;
                end else begin
                    n_state = ST_HOURS;
                    n_div   = HOUR_DIV_START;
                    n_k     = 4'(HOUR_Q_BITS - 1);
                    n_hour  = 5'd0;
                end
            end
            ST_HOURS: begin
                if (w_ge) begin
                    n_rem = w_diff;
                end
                n_hour = {r_hour[3:0], w_ge};
                n_div  = r_div >> 1;
                if (r_k == 4'd0) begin
                    n_state  = ST_MINUTES;
                    n_div    = MIN_DIV_START;
                    n_k      = 4'(MIN_Q_BITS - 1);
                    n_minute = 6'd0;
                end else begin
                    n_k = r_k - 4'd1;
                end
            end
            ST_MINUTES: begin
                if (w_ge) begin
                    n_rem = w_diff;
                end
                n_minute = {r_minute[4:0], w_ge};
                n_div    = r_div >> 1;
                if (r_k == 4'd0) begin
                    n_state = ST_DONE;
                end else begin
                    n_k = r_k - 4'd1;
                end
            end
            ST_DONE: begin
                if (i_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem    <= n_rem;
        r_div    <= n_div;
        r_k      <= n_k;
        r_days   <= n_days;
        r_wd     <= n_wd;
        r_year   <= n_year;
        r_y4     <= n_y4;
        r_y100   <= n_y100;
        r_y400   <= n_y400;
        r_mon    <= n_mon;
        r_hour   <= n_hour;
        r_minute <= n_minute;
    end

    assign o_status.ready = (r_state == ST_IDLE);
    assign o_status.done  = (r_state == ST_DONE);

    // The day count residue plus the epoch weekday, reduced mod 7.
    assign o_result.calendar_year  = r_year;
    assign o_result.calendar_month = r_mon + 4'd1;
    assign o_result.day_of_month   = r_days[4:0] + 5'd1;
    assign o_result.weekday_number = (r_wd >= 3'd3) ? r_wd - 3'd3 : r_wd + EPOCH_WEEKDAY;
    assign o_result.clock_hour     = r_hour;
    assign o_result.clock_minute   = r_minute;
    assign o_result.clock_second   = r_rem[5:0];

`ifndef SYNTHESIS
    a_start_goes_days: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_start) |=> (r_state == ST_DAYS))
        else $error("start did not enter the day division");
    a_month_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MONTHS) |-> (r_mon <= MONTH_DECEMBER))
        else $error("month index ran past December");
    a_year_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MONTHS) |-> (r_year >= BASE_YEAR && r_year <= 12'd2106))
        else $error("year out of range");
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !i_take) |=> (r_state == ST_DONE && $stable(o_result)))
        else $error("finished result changed before it was taken");
`endif

endmodule

// ===== rtl/epoch_seconds_to_calendar_unit.sv =====
// Top level of the epoch seconds to calendar converter.
// Depends on ecal_pkg, ecal_if and ecal_core (which uses ecal_csub).
//
//   channel  direction  payload
//   i_req    in         epoch_seconds[31:0]
//   o_res    out        year, month, day, weekday, hour, minute, second
//
// One request runs in order: 16 restoring steps for whole days,
// one step per year walked plus one, one per month walked plus one,
// 5 and 6 steps for hour and minute, and the done state that hands the result over.
// All steps share a single 32-bit compare and subtract unit.
// Reset is synchronous and active low; it returns the sequencer to idle and
// empties the output register. A result waiting on a stalled o_res does not
// block the next request; only the following one waits until it drains.
module epoch_seconds_to_calendar_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ecal_in_if.sink     i_req,
    ecal_out_if.source  o_res
);
    import ecal_pkg::*;

    t_ecal_status w_status;
    t_ecal_result w_result;
    logic         w_start;
    logic         w_take;

    logic         r_out_valid, n_out_valid;
    t_ecal_result r_out;

    // A request is taken only while the sequencer is idle.
    assign i_req.ready = w_status.ready;
    assign w_start     = i_req.valid && w_status.ready;

    // The finished result moves to the output register whenever that register
    // is empty or is being emptied in the same cycle.
    assign w_take = w_status.done && (!r_out_valid || o_res.ready);

    ecal_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_secs   (i_req.epoch_seconds),
        .i_take   (w_take),
        .o_status (w_status),
        .o_result (w_result)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_take) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // The payload register needs no reset; it is qualified by r_out_valid.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= w_result;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.calendar_year  = r_out.calendar_year;
    assign o_res.calendar_month = r_out.calendar_month;
    assign o_res.day_of_month   = r_out.day_of_month;
    assign o_res.weekday_number = r_out.weekday_number;
    assign o_res.clock_hour     = r_out.clock_hour;
    assign o_res.clock_minute   = r_out.clock_minute;
    assign o_res.clock_second   = r_out.clock_second;

endmodule

// ===== sim/tb.sv =====
// Testbench for the epoch seconds to calendar converter.
// Holds an independent calendar predictor, a request driver and a result checker.
// Depends on ecal_pkg, ecal_if and the epoch_seconds_to_calendar_unit RTL.
module tb;
    import ecal_pkg::*;

    // A request that has gone in, with the date and time it must come back as.
    typedef struct {
        logic [31:0]  secs;
        t_ecal_result want;
    } pending_date_t;

    // The block is slowest on late dates, where the year walk is long. The
    // watchdog limit sits far above such a request plus any likely run of random stalls.
    localparam int unsigned QUIET_LIMIT  = 20000;
    localparam int unsigned SETTLE_TIME  = 200;
    localparam int unsigned PHASE_ITEMS  = 450;
    localparam int unsigned REPORT_LINES = 100;

    logic i_clk;
    logic i_rst_n;

    ecal_in_if  req_ch ();
    ecal_out_if res_ch ();

    epoch_seconds_to_calendar_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    pending_date_t pending_dates [$];
    pending_date_t oldest_date;
    int unsigned   mismatch_count = 0;
    int unsigned   quiet_cycles = 0;
    int unsigned   sender_idle_pct;
    int unsigned   receiver_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Gregorian leap rule: every fourth year, except centuries not divisible
    // by 400.
    function automatic bit leap_year_rule(input int unsigned yr);
        return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    // Predicts the calendar date, weekday and time of day of an epoch count.
    // Whole years are peeled off first, then whole months; whatever days are
    // left give the day of the month. The weekday comes from a congruence in
    // which January and February are months 13 and 14 of the year before.
    function automatic t_ecal_result civil_time_of(input logic [31:0] secs);
        int unsigned  day_count;
        int unsigned  tod;
        int unsigned  yr;
        int unsigned  year_days;
        int unsigned  mon;
        int unsigned  month_days;
        int unsigned  wy;
        int unsigned  wm;
        int unsigned  wsum;
        bit           leap_yr;
        t_ecal_result r;
        day_count = secs / SECONDS_PER_DAY;
        tod       = secs % SECONDS_PER_DAY;
        yr        = BASE_YEAR;
        year_days = leap_year_rule(yr) ? DAYS_LEAP_YEAR : DAYS_COMMON_YEAR;
        while (day_count >= year_days) begin
            day_count -= year_days;
            yr++;
            year_days = leap_year_rule(yr) ? DAYS_LEAP_YEAR : DAYS_COMMON_YEAR;
        end
        // A leap year keeps its last day: 365 days left means 31 December.
        leap_yr = leap_year_rule(yr);
        mon     = 0;
        month_days = 31;
        while (mon < MONTH_DECEMBER && day_count >= month_days) begin
            day_count -= month_days;
            mon++;
            if (mon == MONTH_FEBRUARY)
                month_days = leap_yr ? DAYS_LEAP_FEBRUARY : 28;
            else if (mon == 3 || mon == 5 || mon == 8 || mon == 10)
                month_days = 30;
            else
                month_days = 31;
        end
        wy = yr;
        wm = mon + 1;
        if (wm < 3) begin
            wm += 12;
            wy -= 1;
        end
        wsum = (day_count + 1) + 1 + 2 * wm + (3 * (wm + 1)) / 5
               + wy + wy / 4 - wy / 100 + wy / 400;
        r.calendar_year  = 12'(yr);
        r.calendar_month = 4'(mon + 1);
        r.day_of_month   = 5'(day_count + 1);
        r.weekday_number = 3'(wsum % 7);
        r.clock_hour     = 5'(tod / SECONDS_PER_HOUR);
        r.clock_minute   = 6'((tod % SECONDS_PER_HOUR) / SECONDS_PER_MIN);
        r.clock_second   = 6'(tod % SECONDS_PER_MIN);
        return r;
    endfunction

    // Prints one line per mismatch, up to a cap so a broken block cannot
    // flood the log, and counts every one of them.
    task automatic report_mismatch(input string what, input logic [31:0] secs,
                                   input int unsigned got, input int unsigned want);
        mismatch_count++;
        if (mismatch_count <= REPORT_LINES)
            $display("mismatch: %s for request %0d: got %0d, want %0d",
                     what, secs, got, want);
    endtask

    // Sends one request. The sender may idle first, dropping valid for whole
    // cycles. Valid is left high after the handshake so that back-to-back
    // requests never lower and raise it within one time step; the next call,
    // or the caller, lowers it.
    task automatic send_request(input logic [31:0] secs);
        pending_date_t entry;
        while ($urandom_range(99) < sender_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.epoch_seconds <= secs;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
        entry.secs = secs;
        entry.want = civil_time_of(secs);
        pending_dates.push_back(entry);
    endtask

    // Holds the request channel quiet until every outstanding request has
    // come back, so the block goes fully idle at least once mid-run.
    task automatic wait_for_drain();
        req_ch.valid <= 1'b0;
        while (pending_dates.size() != 0)
            @(posedge i_clk);
    endtask

    // Hour, minute and second at both ends of their ranges, and the first
    // day boundary.
    task automatic test_time_of_day_extremes();
        send_request(32'd0);
        send_request(32'd59);
        send_request(32'd60);
        send_request(32'd3599);
        send_request(32'd3600);
        send_request(32'd86399);
        send_request(32'd86400);
    endtask

    // Year ends of common and leap years, 29 February in a leap year, the
    // leap century 2000 and the common century 2100, and the December
    // limit of the month walk.
    task automatic test_leap_year_rules();
        send_request(32'd31449600);     // 1970-12-31
        send_request(32'd31535999);     // last second of 1970
        send_request(32'd31536000);     // 1971-01-01
        send_request(32'd68083200);     // 1972-02-28
        send_request(32'd68169600);     // 1972-02-29
        send_request(32'd94608000);     // 1972-12-31, the 366th day
        send_request(32'd94694399);     // last second of 1972
        send_request(32'd951782400);    // 2000-02-29
        send_request(32'd951868800);    // 2000-03-01
        send_request(32'd978307199);    // last second of 2000
        send_request(32'd4107542399);   // 2100-02-28, no leap day that year
        send_request(32'd4107542400);   // 2100-03-01
    endtask

    // The top of the input range, the signed rollover and alternating bits.
    task automatic test_input_range_extremes();
        send_request(32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFE);
        send_request(32'h7FFF_FFFF);
        send_request(32'h8000_0000);
        send_request(32'hAAAA_AAAA);
        send_request(32'h5555_5555);
    endtask

    // Random requests. Most are uniform over the whole range; some land a
    // few seconds around a midnight, where day, month and year roll over;
    // some stay in the first decades, where the year walk is short.
    task automatic test_random_conversions(input int unsigned count);
        logic [31:0] secs;
        int unsigned pick;
        repeat (count) begin
            pick = $urandom_range(9);
            if (pick < 6)
                secs = $urandom;
            else if (pick < 9)
                secs = ($urandom / SECONDS_PER_DAY) * SECONDS_PER_DAY
                       + $urandom_range(4) - 2;
            else
                secs = $urandom_range(32'd30 * DAYS_LEAP_YEAR * SECONDS_PER_DAY);
            send_request(secs);
        end
    endtask

    // The receiver stalls at random at the rate of the current phase.
    always @(posedge i_clk)
        res_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);

    // Every accepted result is checked field by field against the oldest
    // outstanding request.
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_dates.size() == 0) begin
                report_mismatch("result with no request", 32'd0,
                                res_ch.calendar_year, 0);
            end else begin
                oldest_date = pending_dates.pop_front();
                if (res_ch.calendar_year !== oldest_date.want.calendar_year)
                    report_mismatch("year", oldest_date.secs, res_ch.calendar_year,
                                    oldest_date.want.calendar_year);
                if (res_ch.calendar_month !== oldest_date.want.calendar_month)
                    report_mismatch("month", oldest_date.secs, res_ch.calendar_month,
                                    oldest_date.want.calendar_month);
                if (res_ch.day_of_month !== oldest_date.want.day_of_month)
                    report_mismatch("day", oldest_date.secs, res_ch.day_of_month,
                                    oldest_date.want.day_of_month);
                if (res_ch.weekday_number !== oldest_date.want.weekday_number)
                    report_mismatch("weekday", oldest_date.secs, res_ch.weekday_number,
                                    oldest_date.want.weekday_number);
                if (res_ch.clock_hour !== oldest_date.want.clock_hour)
                    report_mismatch("hour", oldest_date.secs, res_ch.clock_hour,
                                    oldest_date.want.clock_hour);
                if (res_ch.clock_minute !== oldest_date.want.clock_minute)
                    report_mismatch("minute", oldest_date.secs, res_ch.clock_minute,
                                    oldest_date.want.clock_minute);
                if (res_ch.clock_second !== oldest_date.want.clock_second)
                    report_mismatch("second", oldest_date.secs, res_ch.clock_second,
                                    oldest_date.want.clock_second);
            end
        end
    end

    // The watchdog ends a run in which neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        sender_idle_pct      = 10;
        receiver_stall_pct   = 88;
        i_rst_n              <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.epoch_seconds <= 32'd0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // First phase: a busy sender against a receiver that mostly stalls,
        // so results back up behind o_res.
        test_time_of_day_extremes();
        test_leap_year_rules();
        test_input_range_extremes();
        test_random_conversions(PHASE_ITEMS);
        wait_for_drain();

        // Second phase: a sparse sender against an eager receiver, so the
        // block often sits idle between requests.
        sender_idle_pct    = 88;
        receiver_stall_pct = 10;
        test_random_conversions(PHASE_ITEMS);

        // Last phase: no idling on either side.
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        test_random_conversions(PHASE_ITEMS);

        wait_for_drain();
        repeat (SETTLE_TIME) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
